// File: hw/rtl/ntl_pkg.sv
// ----------------------------------------------------------------------------
// ntl_pkg
// Shared types and constants of the NTC thermistor linearizer.
// ----------------------------------------------------------------------------
package ntl_pkg;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_HI    = 2'd2,
        ST_LO    = 2'd3
    } status_t;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_SAMPLE = 2'd1;
    localparam logic [1:0] ERR_CALC   = 2'd2;

    localparam logic [2:0] REG_GROUND  = 3'd0;
    localparam logic [2:0] REG_NOMINAL = 3'd1;
    localparam logic [2:0] REG_BETA    = 3'd2;
    localparam logic [2:0] REG_REF     = 3'd3;
    localparam logic [2:0] REG_BETAREF = 3'd4;
    localparam logic [2:0] REG_ADC_MIN = 3'd5;
    localparam logic [2:0] REG_ADC_MAX = 3'd6;

    localparam int CFG_W = 22;

    localparam logic signed [31:0] LN2_Q24     = 32'sd11629080;
    localparam logic signed [18:0] KELVIN_Q8   = 19'sd69888;
    localparam logic [17:0]        K8_SAT      = 18'd200960;
    localparam logic signed [9:0]  TEMP_MAX    = 10'sd511;
    localparam logic signed [9:0]  TEMP_MIN    = -10'sd511 - 10'sd1;

    localparam logic [23:0] LN_TABLE [0:16] = '{
        24'd0,       24'd1017112, 24'd1976071, 24'd2883169, 24'd3743728,
        24'd4562291, 24'd5342767, 24'd6088544, 24'd6802576, 24'd7487455,
        24'd8145469, 24'd8778647, 24'd9388795, 24'd9977530, 24'd10546303,
        24'd11096507, 24'd11629080
    };

endpackage

// File: hw/rtl/ntl_div_pipe.sv
// ----------------------------------------------------------------------------
// ntl_div_pipe
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module ntl_div_pipe #(
    parameter int DIV_W = 32,
    parameter int QUO_W = 32,
    parameter int SB_W  = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [DIV_W-1:0] in_rem,
    input  logic [QUO_W-1:0] in_bits,
    input  logic [DIV_W-1:0] in_divisor,
    input  logic [SB_W-1:0]  in_sb,
    output logic             out_valid,
    output logic [QUO_W-1:0] out_quo,
    output logic [SB_W-1:0]  out_sb
);

    logic             vld_reg  [QUO_W];
    logic [DIV_W-1:0] rem_reg  [QUO_W];
    logic [QUO_W-1:0] word_reg [QUO_W];
    logic [DIV_W-1:0] div_reg  [QUO_W];
    logic [SB_W-1:0]  sb_reg   [QUO_W];

    logic [DIV_W-1:0] rem_next  [QUO_W];
    logic [QUO_W-1:0] word_next [QUO_W];

    genvar k;
    generate
        for (k = 0; k < QUO_W; k++) begin : g_stage
            logic [DIV_W-1:0] rem_src;
            logic [QUO_W-1:0] word_src;
            logic [DIV_W-1:0] div_src;
            logic [DIV_W:0]   shifted;
            logic             ge;

            if (k == 0) begin : g_first
                assign rem_src  = in_rem;
                assign word_src = in_bits;
                assign div_src  = in_divisor;
            end else begin : g_rest
                assign rem_src  = rem_reg[k-1];
                assign word_src = word_reg[k-1];
                assign div_src  = div_reg[k-1];
            end

            always_comb begin
                shifted      = {rem_src, word_src[QUO_W-1]};
                ge           = (shifted >= {1'b0, div_src});
                rem_next[k]  = ge ? DIV_W'(shifted - {1'b0, div_src}) : shifted[DIV_W-1:0];
                word_next[k] = {word_src[QUO_W-2:0], ge};
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[k] <= 1'b0;
                end else if (en) begin
                    vld_reg[k] <= (k == 0) ? in_valid : vld_reg[(k == 0) ? 0 : k-1];
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k]  <= rem_next[k];
                    word_reg[k] <= word_next[k];
                    div_reg[k]  <= div_src;
                    sb_reg[k]   <= (k == 0) ? in_sb : sb_reg[(k == 0) ? 0 : k-1];
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[QUO_W-1];
    assign out_quo   = word_reg[QUO_W-1];
    assign out_sb    = sb_reg[QUO_W-1];

endmodule

// File: hw/rtl/ntc_thermistor_linearizer_unit.sv
// ----------------------------------------------------------------------------
// ntc_thermistor_linearizer_unit
// Converts NTC divider samples to whole degrees Celsius via the beta equation.
// ----------------------------------------------------------------------------
//  channel   dir  word contents (lsb up)
//  s_axis    in   adc_sample
//  m_axis    out  temperature_c[9:0], fault[11:10]
//  cfg       in   cfg_addr selects register, cfg_wdata value
//
//  One word accepted per cycle while no m_axis stall holds the pipeline; it spans
//  two bit-serial divider pipelines (32 and 18 stages) plus log and product stages.
//  aresetn is synchronous: clears all valid bits and loads register defaults.
//  A stall on m_axis holds the whole pipeline only once its last stage is full.
// ----------------------------------------------------------------------------
module ntc_thermistor_linearizer_unit #(
    parameter int ADC_BITS = 12
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((ADC_BITS+7)/8)*8-1:0]       s_tdata,   // adc_sample
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [15:0]                         m_tdata,   // temperature_c, fault
    input  logic                                cfg_wr_en,
    input  logic [2:0]                          cfg_addr,
    input  logic [ntl_pkg::CFG_W-1:0]           cfg_wdata
);
    import ntl_pkg::*;

    localparam int CMP_W = (ADC_BITS > 12) ? ADC_BITS : 12;

    logic [19:0] grnd_reg, nom_reg;
    logic [13:0] beta_reg;
    logic [8:0]  ref_reg;
    logic [21:0] btr_reg;
    logic [11:0] amin_reg, amax_reg;

    logic pipe_en, out_free;

    // stage valids
    logic p0_vld_reg, s1_vld_reg, s2_vld_reg;
    logic l1_vld_reg, l2_vld_reg, l3_vld_reg, l4_vld_reg;
    logic l5_vld_reg, l6_vld_reg, l7_vld_reg, l8_vld_reg;
    logic f_vld_reg, out_vld_reg;

    // payload
    logic [ADC_BITS-1:0] p0_adc_reg;
    status_t             s1_st_reg, s2_st_reg, l1_st_reg, l2_st_reg, l3_st_reg;
    status_t             l4_st_reg, l5_st_reg, l6_st_reg, l7_st_reg, l8_st_reg;
    logic [31:0]         s1_num_reg, s1_den_reg, s2_num_reg, s2_den_reg;
    logic [31:0]         l1_x_reg;
    logic [4:0]          l1_p_reg;
    logic [3:0]          l2_idx_reg;
    logic [19:0]         l2_rm_reg, l3_rm_reg;
    logic signed [5:0]   l2_e_reg, l3_e_reg;
    logic [23:0]         l3_base_reg, l4_base_reg;
    logic [19:0]         l3_diff_reg, l4_step_reg;
    logic signed [31:0]  l4_eln_reg, l5_ln_reg;
    logic signed [41:0]  l6_prod_reg, l7_d_reg;
    logic [38:0]         l8_d_reg;
    logic signed [9:0]   f_temp_reg;
    logic [1:0]          f_err_reg;
    logic signed [9:0]   out_temp_reg;
    logic [1:0]          out_err_reg;

    // divider outputs
    logic        d1_vld, d2_vld;
    logic [31:0] d1_quo;
    logic [17:0] d2_quo;
    logic [1:0]  d1_sb, d2_sb;

    assign out_free = !out_vld_reg || m_tready;
    assign pipe_en  = out_free || !f_vld_reg;
    assign s_tready = pipe_en;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {4'b0, out_err_reg, out_temp_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grnd_reg <= 20'd10000;
            nom_reg  <= 20'd10000;
            beta_reg <= 14'd3950;
            ref_reg  <= 9'd298;
            btr_reg  <= 22'd1177100;
            amin_reg <= 12'd1;
            amax_reg <= 12'd4095;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_GROUND:  grnd_reg <= cfg_wdata[19:0];
                REG_NOMINAL: nom_reg  <= cfg_wdata[19:0];
                REG_BETA:    beta_reg <= cfg_wdata[13:0];
                REG_REF:     ref_reg  <= cfg_wdata[8:0];
                REG_BETAREF: btr_reg  <= cfg_wdata[21:0];
                REG_ADC_MIN: amin_reg <= cfg_wdata[11:0];
                REG_ADC_MAX: amax_reg <= cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    // stage 1: range check and divider operands
    logic [CMP_W-1:0] adc_ext;
    logic [11:0]      adc12;
    status_t          s1_st_next;
    logic [31:0]      s1_num_next, s1_den_next;

    always_comb begin
        adc_ext     = CMP_W'(p0_adc_reg);
        adc12       = adc_ext[11:0];
        s1_st_next  = ((adc_ext < CMP_W'(amin_reg)) || (adc_ext > CMP_W'(amax_reg)))
                      ? ST_RANGE : ST_OK;
        s1_num_next = 32'(grnd_reg) * 32'(12'(amax_reg - adc12));
        s1_den_next = 32'(adc12) * 32'(nom_reg);
    end

    // stage 2: zero and overflow detection
    status_t s2_st_next;

    always_comb begin
        s2_st_next = s1_st_reg;
        if (s1_st_reg == ST_OK) begin
            if (s1_num_reg == 32'd0) begin
                s2_st_next = ST_HI;
            end else if (s1_den_reg == 32'd0) begin
                s2_st_next = ST_LO;
            end else if ({8'b0, s1_num_reg} >= {s1_den_reg, 8'b0}) begin
                s2_st_next = ST_LO;
            end
        end
    end

    ntl_div_pipe #(.DIV_W(32), .QUO_W(32), .SB_W(2)) u_ratio_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (pipe_en),
        .in_valid   (s2_vld_reg),
        .in_rem     ({8'b0, s2_num_reg[31:8]}),
        .in_bits    ({s2_num_reg[7:0], 24'b0}),
        .in_divisor (s2_den_reg),
        .in_sb      (s2_st_reg),
        .out_valid  (d1_vld),
        .out_quo    (d1_quo),
        .out_sb     (d1_sb)
    );

    // log stages
    status_t     l1_st_next;
    logic [4:0]  lz_p;
    logic [31:0] norm;
    logic [4:0]  tab_i;
    logic [23:0] tab_lo, tab_hi;
    logic [39:0] step_prod;
    logic signed [31:0] e_ext;

    always_comb begin
        l1_st_next = status_t'(d1_sb);
        if ((l1_st_next == ST_OK) && (d1_quo == 32'd0)) begin
            l1_st_next = ST_HI;
        end
        lz_p = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (d1_quo[i]) begin
                lz_p = 5'(i);
            end
        end
        norm      = l1_x_reg << (5'd31 - l1_p_reg);
        tab_i     = {1'b0, l2_idx_reg};
        tab_lo    = LN_TABLE[tab_i];
        tab_hi    = LN_TABLE[5'(tab_i + 5'd1)];
        step_prod = 40'(l3_diff_reg) * 40'(l3_rm_reg);
        e_ext     = 32'(l3_e_reg);
    end

    // denominator checks
    status_t     l8_st_next;
    logic signed [41:0] d_next;

    always_comb begin
        d_next     = l6_prod_reg + $signed({4'b0, beta_reg, 24'b0});
        l8_st_next = l7_st_reg;
        if (l7_st_reg == ST_OK) begin
            if (l7_d_reg <= 42'sd0) begin
                l8_st_next = ST_HI;
            end else if ({6'b0, btr_reg, 14'b0} >= l7_d_reg) begin
                l8_st_next = ST_HI;
            end
        end
    end

    ntl_div_pipe #(.DIV_W(39), .QUO_W(18), .SB_W(2)) u_kelvin_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (pipe_en),
        .in_valid   (l8_vld_reg),
        .in_rem     ({3'b0, btr_reg, 14'b0}),
        .in_bits    (18'd0),
        .in_divisor (l8_d_reg),
        .in_sb      (l8_st_reg),
        .out_valid  (d2_vld),
        .out_quo    (d2_quo),
        .out_sb     (d2_sb)
    );

    // final stage: kelvin to celsius, saturate
    logic signed [18:0] c8;
    logic [18:0]        mag;
    logic [9:0]         whole;
    logic signed [9:0]  f_temp_next;
    logic [1:0]         f_err_next;

    always_comb begin
        c8    = $signed({1'b0, d2_quo}) - KELVIN_Q8;
        mag   = c8[18] ? 19'(-c8) : c8;
        whole = mag[17:8];
        case (status_t'(d2_sb))
            ST_OK: begin
                if (d2_quo >= K8_SAT) begin
                    f_temp_next = TEMP_MAX;
                    f_err_next  = ERR_CALC;
                end else begin
                    f_temp_next = c8[18] ? -$signed(whole) : $signed(whole);
                    f_err_next  = ERR_NONE;
                end
            end
            ST_RANGE: begin
                f_temp_next = 10'sd0;
                f_err_next  = ERR_SAMPLE;
            end
            ST_HI: begin
                f_temp_next = TEMP_MAX;
                f_err_next  = ERR_CALC;
            end
            default: begin
                f_temp_next = TEMP_MIN;
                f_err_next  = ERR_CALC;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_vld_reg  <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            l1_vld_reg  <= 1'b0;
            l2_vld_reg  <= 1'b0;
            l3_vld_reg  <= 1'b0;
            l4_vld_reg  <= 1'b0;
            l5_vld_reg  <= 1'b0;
            l6_vld_reg  <= 1'b0;
            l7_vld_reg  <= 1'b0;
            l8_vld_reg  <= 1'b0;
            f_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (pipe_en) begin
                p0_vld_reg <= s_tvalid;
                s1_vld_reg <= p0_vld_reg;
                s2_vld_reg <= s1_vld_reg;
                l1_vld_reg <= d1_vld;
                l2_vld_reg <= l1_vld_reg;
                l3_vld_reg <= l2_vld_reg;
                l4_vld_reg <= l3_vld_reg;
                l5_vld_reg <= l4_vld_reg;
                l6_vld_reg <= l5_vld_reg;
                l7_vld_reg <= l6_vld_reg;
                l8_vld_reg <= l7_vld_reg;
                f_vld_reg  <= d2_vld;
            end
            if (out_free) begin
                out_vld_reg <= f_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            p0_adc_reg  <= s_tdata[ADC_BITS-1:0];
            s1_st_reg   <= s1_st_next;
            s1_num_reg  <= s1_num_next;
            s1_den_reg  <= s1_den_next;
            s2_st_reg   <= s2_st_next;
            s2_num_reg  <= s1_num_reg;
            s2_den_reg  <= s1_den_reg;
            l1_st_reg   <= l1_st_next;
            l1_x_reg    <= d1_quo;
            l1_p_reg    <= lz_p;
            l2_st_reg   <= l1_st_reg;
            l2_idx_reg  <= norm[30:27];
            l2_rm_reg   <= norm[26:7];
            l2_e_reg    <= $signed({1'b0, l1_p_reg}) - 6'sd24;
            l3_st_reg   <= l2_st_reg;
            l3_rm_reg   <= l2_rm_reg;
            l3_e_reg    <= l2_e_reg;
            l3_base_reg <= tab_lo;
            l3_diff_reg <= 20'(tab_hi - tab_lo);
            l4_st_reg   <= l3_st_reg;
            l4_base_reg <= l3_base_reg;
            l4_step_reg <= step_prod[39:20];
            l4_eln_reg  <= e_ext * LN2_Q24;
            l5_st_reg   <= l4_st_reg;
            l5_ln_reg   <= l4_eln_reg + $signed({8'b0, l4_base_reg})
                           + $signed({12'b0, l4_step_reg});
            l6_st_reg   <= l5_st_reg;
            l6_prod_reg <= 42'(l5_ln_reg) * $signed({33'b0, ref_reg});
            l7_st_reg   <= l6_st_reg;
            l7_d_reg    <= d_next;
            l8_st_reg   <= l8_st_next;
            l8_d_reg    <= l7_d_reg[38:0];
            f_temp_reg  <= f_temp_next;
            f_err_reg   <= f_err_next;
        end
        if (out_free) begin
            out_temp_reg <= f_temp_reg;
            out_err_reg  <= f_err_reg;
        end
    end

    a_err_code_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_err_reg == ERR_NONE || out_err_reg == ERR_SAMPLE
                      || out_err_reg == ERR_CALC))
        else $error("illegal error code on output");

    a_sample_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_err_reg == ERR_SAMPLE) |-> (out_temp_reg == 10'sd0))
        else $error("out-of-range sample carries a temperature");

    a_stall_holds_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        !pipe_en |=> $stable({p0_vld_reg, s1_vld_reg, s2_vld_reg, l1_vld_reg,
                              l8_vld_reg, f_vld_reg}))
        else $error("pipeline moved while stalled");

    a_no_stall_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !f_vld_reg |-> s_tready)
        else $error("input blocked with an empty last stage");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the NTC thermistor linearizer.
// Streams ADC samples under several register settings and flow-control
// patterns, and compares each temperature / error word against a bit-exact
// fixed-point beta-equation model.
// ----------------------------------------------------------------------------
module tb;
    import ntl_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LATENCY_WAIT   = 100;
    localparam logic [2:0] REG_UNUSED = 3'd7;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [15:0]           m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [2:0]            cfg_addr = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    logic [19:0] ground_ohms;
    logic [19:0] nominal_ohms;
    logic [13:0] beta_k;
    logic [8:0]  ref_k;
    logic [21:0] beta_ref;
    logic [11:0] adc_lo;
    logic [11:0] adc_hi;

    logic [11:0] temps_expected [$];
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          error_count = 0;
    int          quiet_cycles = 0;

    ntc_thermistor_linearizer_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // {fault, temperature_c}
    function automatic logic [11:0] convert_sample(logic [11:0] adc);
        longint unsigned num, den, ratio, m, frac, idx, rem, step;
        logic [31:0] x;
        int p;
        longint lnv, d, k8, c8, t;
        logic [1:0] err;
        t = 0;
        err = ERR_NONE;
        if (adc < adc_lo || adc > adc_hi) begin
            err = ERR_SAMPLE;
        end else begin
            num = longint'(ground_ohms) * longint'(adc_hi - adc);
            den = longint'(adc) * longint'(nominal_ohms);
            if (num == 0) begin
                err = ERR_CALC; t = TEMP_MAX;
            end else if (den == 0) begin
                err = ERR_CALC; t = TEMP_MIN;
            end else begin
                ratio = (num << 24) / den;
                if (ratio > 64'hFFFF_FFFF) begin
                    err = ERR_CALC; t = TEMP_MIN;
                end else if (ratio == 0) begin
                    err = ERR_CALC; t = TEMP_MAX;
                end else begin
                    x = ratio[31:0];
                    p = 31;
                    while (p > 0 && x[p] == 1'b0) p--;
                    if (p >= 24) m = x >> (p - 24);
                    else m = 64'(x) << (24 - p);
                    frac = m - (64'd1 << 24);
                    idx = (frac >> 20) & 15;
                    rem = frac & 64'hF_FFFF;
                    step = ((longint'(LN_TABLE[idx + 1]) - longint'(LN_TABLE[idx])) * rem) >> 20;
                    lnv = longint'(p - 24) * longint'(LN2_Q24) + longint'(LN_TABLE[idx])
                        + longint'(step);
                    d = lnv * longint'(ref_k) + (longint'(beta_k) <<< 24);
                    if (d <= 0) begin
                        err = ERR_CALC; t = TEMP_MAX;
                    end else begin
                        k8 = longint'((longint'(beta_ref) << 32) / longint'(d));
                        c8 = k8 - 273 * 256;
                        t = c8 / 256;
                        if (t > TEMP_MAX) begin
                            t = TEMP_MAX; err = ERR_CALC;
                        end else if (t < TEMP_MIN) begin
                            t = TEMP_MIN; err = ERR_CALC;
                        end
                    end
                end
            end
        end
        return {err, t[9:0]};
    endfunction

    always @(posedge aclk) begin
        logic [11:0] want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
            if (m_tvalid && m_tready) begin
                if (temps_expected.size() == 0) begin
                    $display("%0t: unexpected word, got temp %0d err %0d", $time,
                             $signed(m_tdata[9:0]), m_tdata[11:10]);
                    error_count++;
                end else begin
                    want = temps_expected.pop_front();
                    if (m_tdata[9:0] !== want[9:0]) begin
                        $display("%0t: temperature expected %0d actual %0d", $time,
                                 $signed(want[9:0]), $signed(m_tdata[9:0]));
                        error_count++;
                    end
                    if (m_tdata[11:10] !== want[11:10]) begin
                        $display("%0t: error code expected %0d actual %0d", $time,
                                 want[11:10], m_tdata[11:10]);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_sample(logic [11:0] adc);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, adc};
        do @(posedge aclk); while (!s_tready);
        temps_expected.push_back(convert_sample(adc));
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (temps_expected.size() != 0) @(posedge aclk);
        repeat (LATENCY_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        @(posedge aclk);
        case (addr)
            REG_GROUND:  ground_ohms  = val[19:0];
            REG_NOMINAL: nominal_ohms = val[19:0];
            REG_BETA:    beta_k       = val[13:0];
            REG_REF:     ref_k        = val[8:0];
            REG_BETAREF: beta_ref     = val[21:0];
            REG_ADC_MIN: adc_lo       = val[11:0];
            REG_ADC_MAX: adc_hi       = val[11:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(int g, int n, int b, int r, int br, int lo, int hi);
        drain();
        write_reg(REG_GROUND, CFG_W'(g));
        write_reg(REG_NOMINAL, CFG_W'(n));
        write_reg(REG_BETA, CFG_W'(b));
        write_reg(REG_REF, CFG_W'(r));
        write_reg(REG_BETAREF, CFG_W'(br));
        write_reg(REG_ADC_MIN, CFG_W'(lo));
        write_reg(REG_ADC_MAX, CFG_W'(hi));
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [11:0] pick_sample();
        if ($urandom_range(99) < 85 && adc_lo <= adc_hi)
            return 12'($urandom_range(adc_hi, adc_lo));
        return 12'($urandom_range(4095));
    endfunction

    task automatic test_defaults;
        logic [11:0] picks [] = '{12'd0, 12'd1, 12'd2, 12'd4095, 12'd4094, 12'd2048,
                                  12'd2047, 12'd1024, 12'd3072, 12'd100, 12'd4000,
                                  12'd12, 12'hAAA, 12'h555};
        foreach (picks[i]) send_sample(picks[i]);
    endtask

    task automatic test_extremes;
        logic [11:0] wide_picks [] = '{12'd99, 12'd100, 12'd4000, 12'd4001, 12'd0,
                                       12'd101, 12'd2000};
        logic [11:0] edge_picks [] = '{12'd0, 12'd1, 12'd4095, 12'd4094, 12'd2048};
        load_settings(1000000, 1, 10000, 400, 4000000, 100, 4000);
        foreach (wide_picks[i]) send_sample(wide_picks[i]);
        load_settings(1, 1000000, 1, 400, 1, 0, 4095);
        foreach (edge_picks[i]) send_sample(edge_picks[i]);
        load_settings(0, 0, 10000, 1, 4000000, 0, 1);
        send_sample(12'd0);
        send_sample(12'd1);
        load_settings(10000, 10000, 1, 1, 4000000, 0, 4095);
        send_sample(12'd2048);
        send_sample(12'd4000);
        drain();
        write_reg(REG_UNUSED, '1);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        send_sample(12'd2048);
    endtask

    task automatic test_random_phase(int idle, int stall, int count);
        int b, r, lo, hi;
        b  = $urandom_range(10000, 1);
        r  = $urandom_range(400, 1);
        lo = $urandom_range(200);
        hi = $urandom_range(4095, 3800);
        if ($urandom_range(3) == 0)
            load_settings(10000, 10000, 3950, 298, 1177100, 1, 4095);
        else
            load_settings($urandom_range(1000000, 1), $urandom_range(1000000, 1), b, r,
                          ($urandom_range(1) != 0) ? b * r : $urandom_range(4000000, 1),
                          lo, hi);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        repeat (count) send_sample(pick_sample());
    endtask

    task automatic test_random;
        for (int i = 0; i < 4; i++) begin
            test_random_phase(0, 0, 50);
            test_random_phase(74, 0, 50);
            test_random_phase(0, 74, 50);
            test_random_phase(7, 7, 50);
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        ground_ohms  = 20'd10000;
        nominal_ohms = 20'd10000;
        beta_k       = 14'd3950;
        ref_k        = 9'd298;
        beta_ref     = 22'd1177100;
        adc_lo       = 12'd1;
        adc_hi       = 12'd4095;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_defaults();
        test_extremes();
        test_random();
        drain();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
